### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the longest path search core.
// Each macro uses the clk and rst_n of the module that expands it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DLP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DLP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DLP_ASSERT_IMP(lbl, ante, cons, msg)
`define DLP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/dlp_pkg.sv
// Shared sizes, codes, types and helper functions of the longest path search core.
// No dependencies; every other RTL file imports this package.
package dlp_pkg;

    localparam int NODES   = 128;
    localparam int EDGES   = 1024;
    localparam int FIELD_W = 7;
    localparam int MODE_W  = 2;
    localparam int ERR_W   = 2;
    localparam int DIST_W  = 16;

    localparam int NODE_AW      = $clog2(NODES);
    localparam int NODE_CW      = $clog2(NODES + 1);
    localparam int EDGE_AW      = (EDGES > 1) ? $clog2(EDGES) : 1;
    localparam int ECNT_W       = (EDGES > 1) ? $clog2(EDGES + 1) : 1;
    localparam int EDGE_ENTRY_W = 2 * FIELD_W;

    localparam int S_TDATA_W = ((3 * FIELD_W + 7) / 8) * 8;
    localparam int S_TUSER_W = MODE_W;
    localparam int M_TDATA_W = ((2 * FIELD_W + 7) / 8) * 8;
    localparam int M_TUSER_W = ERR_W;

    typedef logic [FIELD_W-1:0]      field_t;
    typedef logic [MODE_W-1:0]       mode_t;
    typedef logic [ERR_W-1:0]        err_t;
    typedef logic [DIST_W-1:0]       dist_t;
    typedef logic [NODE_AW-1:0]      node_addr_t;
    typedef logic [NODE_CW-1:0]      node_cnt_t;
    typedef logic [EDGE_AW-1:0]      edge_addr_t;
    typedef logic [ECNT_W-1:0]       edge_cnt_t;
    typedef logic [EDGE_ENTRY_W-1:0] edge_entry_t;

    localparam mode_t MODE_CLEAR = 2'd0;
    localparam mode_t MODE_ADD   = 2'd1;
    localparam mode_t MODE_RUN   = 2'd2;

    localparam err_t ERR_OK       = 2'd0;
    localparam err_t ERR_OVERFLOW = 2'd1;
    localparam err_t ERR_CYCLE    = 2'd2;

    localparam dist_t DIST_UNREACHED = {DIST_W{1'b1}};

    typedef struct packed {
        logic       clear;
        logic       add;
        field_t     from;
        field_t     to;
        logic       rd_en;
        edge_addr_t rd_addr;
    } edge_cmd_t;

    typedef struct packed {
        edge_cnt_t count;
        logic      overflow;
    } edge_stat_t;

    typedef struct packed {
        logic       clear_all;
        logic       wr_en;
        node_addr_t wr_addr;
        dist_t      wr_data;
        logic       rd_en;
        node_addr_t rd_addr_a;
        node_addr_t rd_addr_b;
    } dist_req_t;

    typedef struct packed {
        field_t path_length;
        field_t end_node;
        err_t   error_code;
    } result_t;

    function automatic logic node_ok(input field_t n);
        return (int'(n) < NODES);
    endfunction

    function automatic node_addr_t to_addr(input field_t n);
        return node_addr_t'(n);
    endfunction

endpackage

### rtl/dag_longest_path_search_core.sv
// Top level of the longest path search core: stream ports, output register and
// the edge store, distance memory and sequencer. Depends on dlp_pkg and assert_macros.svh.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------------
//  s_axis   | in        | tuser: mode; tdata: edge_from, edge_to, source_node
//  m_axis   | out       | tuser: error_code; tdata: path_length, end_node
//
// A clear or add-edge beat is taken in the idle state and leaves the sequencer idle. A run
// beat closes the input until its result is taken into the output register; it makes at most
// NODES passes over the stored edges and ends with a cycle error if the NODES-th pass grows.
// Each edge is an edge memory read and a read-modify-write of the distance memory.
// Reset empties the edge list; the distance memory needs no clearing pass (valid bits).
// A result waits in the output register while the next beat is taken; a later one stalls.
`include "assert_macros.svh"

module dag_longest_path_search_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // edge_from [6:0], edge_to [13:7], source_node [20:14], zero pad above
    input  logic [dlp_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // mode [1:0]
    input  logic [dlp_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // path_length [6:0], end_node [13:7], zero pad above
    output logic [dlp_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // error_code [1:0]
    output logic [dlp_pkg::M_TUSER_W-1:0]   m_axis_tuser
);
    import dlp_pkg::*;

    logic        in_accept;
    logic        ctrl_idle;
    edge_cmd_t   edge_cmd;
    edge_stat_t  edge_stat;
    edge_entry_t edge_rd;
    dist_req_t   dist_req;
    dist_t       dist_a;
    dist_t       dist_b;
    logic        res_valid;
    logic        res_ready;
    result_t     res;

    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_res_reg;

    assign s_axis_tready = ctrl_idle;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    dlp_edge_store u_edge_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (edge_cmd),
        .stat    (edge_stat),
        .rd_data (edge_rd)
    );

    dlp_dist_ram u_dist_ram (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (dist_req),
        .rd_data_a (dist_a),
        .rd_data_b (dist_b)
    );

    dlp_search_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_mode   (mode_t'(s_axis_tuser[MODE_W-1:0])),
        .in_from   (s_axis_tdata[FIELD_W-1:0]),
        .in_to     (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
        .in_src    (s_axis_tdata[3*FIELD_W-1:2*FIELD_W]),
        .idle      (ctrl_idle),
        .edge_cmd  (edge_cmd),
        .edge_stat (edge_stat),
        .edge_rd   (edge_rd),
        .dist_req  (dist_req),
        .dist_a    (dist_a),
        .dist_b    (dist_b),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({out_res_reg.end_node, out_res_reg.path_length});
    assign m_axis_tuser  = M_TUSER_W'(out_res_reg.error_code);

    `DLP_ASSERT_NXT(a_result_loaded, res_valid && res_ready, m_axis_tvalid, "finished result not presented")
    `DLP_ASSERT_IMP(a_busy_while_waiting, res_valid, !s_axis_tready, "input open before result handed over")

endmodule

### rtl/dlp_edge_store.sv
// Edge list memory with its fill count and overflow flag.
// Depends on dlp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dlp_edge_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dlp_pkg::edge_cmd_t   cmd,
    output dlp_pkg::edge_stat_t  stat,
    output dlp_pkg::edge_entry_t rd_data
);
    import dlp_pkg::*;

    edge_entry_t mem [EDGES];
    edge_entry_t rd_data_reg;
    edge_cnt_t   count_reg;
    edge_cnt_t   count_next;
    logic        overflow_reg;
    logic        overflow_next;
    logic        add_ok;
    logic        full;

    assign add_ok = cmd.add && node_ok(cmd.from) && node_ok(cmd.to);
    assign full   = (count_reg >= edge_cnt_t'(EDGES));

    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (cmd.clear)
        begin
            count_next    = '0;
            overflow_next = 1'b0;
        end
        else if (add_ok)
        begin
            if (full)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + edge_cnt_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (add_ok && !full && !cmd.clear)
        begin
            mem[count_reg[EDGE_AW-1:0]] <= {cmd.from, cmd.to};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    assign stat.count    = count_reg;
    assign stat.overflow = overflow_reg;
    assign rd_data       = rd_data_reg;

    `DLP_ASSERT_NXT(a_ovf_on_full, add_ok && full && !cmd.clear, overflow_reg, "full add did not flag overflow")
    `DLP_ASSERT_NXT(a_clear_empties, cmd.clear, (count_reg == '0) && !overflow_reg, "clear left edges behind")

endmodule

### rtl/dlp_dist_ram.sv
// Node distance memory, two registered read ports and one write port.
// Per-node valid bits make a never-written entry read as unreached. Depends on dlp_pkg.
module dlp_dist_ram (
    input  logic               clk,
    input  logic               rst_n,
    input  dlp_pkg::dist_req_t req,
    output dlp_pkg::dist_t     rd_data_a,
    output dlp_pkg::dist_t     rd_data_b
);
    import dlp_pkg::*;

    dist_t            mem [NODES];
    logic [NODES-1:0] valid_reg;
    logic [NODES-1:0] valid_next;
    dist_t            data_a_reg;
    dist_t            data_b_reg;
    logic             vld_a_reg;
    logic             vld_b_reg;

    always_comb
    begin
        valid_next = req.clear_all ? '0 : valid_reg;
        if (req.wr_en)
        begin
            valid_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (req.rd_en)
            begin
                vld_a_reg <= valid_reg[req.rd_addr_a];
                vld_b_reg <= valid_reg[req.rd_addr_b];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            data_a_reg <= mem[req.rd_addr_a];
            data_b_reg <= mem[req.rd_addr_b];
        end
    end

    assign rd_data_a = vld_a_reg ? data_a_reg : DIST_UNREACHED;
    assign rd_data_b = vld_b_reg ? data_b_reg : DIST_UNREACHED;

endmodule

### rtl/dlp_search_ctrl.sv
// Sequencer: decodes input beats, runs the relaxation passes over the edge list
// and scans the distances for the result. Depends on dlp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dlp_search_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_accept,
    input  dlp_pkg::mode_t       in_mode,
    input  dlp_pkg::field_t      in_from,
    input  dlp_pkg::field_t      in_to,
    input  dlp_pkg::field_t      in_src,
    output logic                 idle,
    output dlp_pkg::edge_cmd_t   edge_cmd,
    input  dlp_pkg::edge_stat_t  edge_stat,
    input  dlp_pkg::edge_entry_t edge_rd,
    output dlp_pkg::dist_req_t   dist_req,
    input  dlp_pkg::dist_t       dist_a,
    input  dlp_pkg::dist_t       dist_b,
    output logic                 res_valid,
    input  logic                 res_ready,
    output dlp_pkg::result_t     res
);
    import dlp_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_EREAD    = 3'd1;
    localparam logic [2:0] ST_DREAD    = 3'd2;
    localparam logic [2:0] ST_UPD      = 3'd3;
    localparam logic [2:0] ST_SCAN_RD  = 3'd4;
    localparam logic [2:0] ST_SCAN_CHK = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    edge_cnt_t  edge_idx_reg;
    edge_cnt_t  edge_idx_next;
    node_cnt_t  pass_cnt_reg;
    node_cnt_t  pass_cnt_next;
    logic       grew_reg;
    logic       grew_next;
    logic       cycle_reg;
    logic       cycle_next;
    node_addr_t head_reg;
    node_addr_t head_next;
    node_cnt_t  scan_idx_reg;
    node_cnt_t  scan_idx_next;
    dist_t      best_len_reg;
    dist_t      best_len_next;
    field_t     best_node_reg;
    field_t     best_node_next;

    field_t     tail_f;
    field_t     head_f;
    dist_t      cand;

    assign tail_f = edge_rd[EDGE_ENTRY_W-1:FIELD_W];
    assign head_f = edge_rd[FIELD_W-1:0];
    assign cand   = dist_a + dist_t'(1);

    always_comb
    begin
        state_next     = state_reg;
        edge_idx_next  = edge_idx_reg;
        pass_cnt_next  = pass_cnt_reg;
        grew_next      = grew_reg;
        cycle_next     = cycle_reg;
        head_next      = head_reg;
        scan_idx_next  = scan_idx_reg;
        best_len_next  = best_len_reg;
        best_node_next = best_node_reg;
        edge_cmd       = '0;
        dist_req       = '0;
        res_valid      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (in_mode)
                        MODE_CLEAR:
                        begin
                            edge_cmd.clear = 1'b1;
                        end
                        MODE_ADD:
                        begin
                            edge_cmd.add  = 1'b1;
                            edge_cmd.from = in_from;
                            edge_cmd.to   = in_to;
                        end
                        MODE_RUN:
                        begin
                            dist_req.clear_all = 1'b1;
                            edge_idx_next      = '0;
                            pass_cnt_next      = '0;
                            grew_next          = 1'b0;
                            cycle_next         = 1'b0;
                            scan_idx_next      = '0;
                            best_len_next      = '0;
                            best_node_next     = '0;
                            if (node_ok(in_src))
                            begin
                                dist_req.wr_en   = 1'b1;
                                dist_req.wr_addr = to_addr(in_src);
                                dist_req.wr_data = '0;
                                state_next       = ST_EREAD;
                            end
                            else
                            begin
                                state_next = ST_SCAN_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EREAD:
            begin
                if (edge_idx_reg == edge_stat.count)
                begin
                    // End of a pass: stop when nothing grew; a pass that still
                    // grows after NODES-1 growing passes means a reachable cycle.
                    pass_cnt_next = pass_cnt_reg + node_cnt_t'(1);
                    if (!grew_reg)
                    begin
                        state_next = ST_SCAN_RD;
                    end
                    else if (pass_cnt_next == node_cnt_t'(NODES))
                    begin
                        cycle_next = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        edge_idx_next = '0;
                        grew_next     = 1'b0;
                    end
                end
                else
                begin
                    edge_cmd.rd_en   = 1'b1;
                    edge_cmd.rd_addr = edge_idx_reg[EDGE_AW-1:0];
                    state_next       = ST_DREAD;
                end
            end
            ST_DREAD:
            begin
                if (node_ok(tail_f) && node_ok(head_f))
                begin
                    dist_req.rd_en     = 1'b1;
                    dist_req.rd_addr_a = to_addr(tail_f);
                    dist_req.rd_addr_b = to_addr(head_f);
                    head_next          = to_addr(head_f);
                    state_next         = ST_UPD;
                end
                else
                begin
                    edge_idx_next = edge_idx_reg + edge_cnt_t'(1);
                    state_next    = ST_EREAD;
                end
            end
            ST_UPD:
            begin
                if (dist_a != DIST_UNREACHED)
                begin
                    if ((dist_b == DIST_UNREACHED) || (cand > dist_b))
                    begin
                        dist_req.wr_en   = 1'b1;
                        dist_req.wr_addr = head_reg;
                        dist_req.wr_data = cand;
                        grew_next        = 1'b1;
                    end
                end
                edge_idx_next = edge_idx_reg + edge_cnt_t'(1);
                state_next    = ST_EREAD;
            end
            ST_SCAN_RD:
            begin
                if (scan_idx_reg == node_cnt_t'(NODES))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    dist_req.rd_en     = 1'b1;
                    dist_req.rd_addr_a = scan_idx_reg[NODE_AW-1:0];
                    dist_req.rd_addr_b = scan_idx_reg[NODE_AW-1:0];
                    state_next         = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                // Strict compare keeps the smallest node at the greatest distance.
                if ((dist_a != DIST_UNREACHED) && (dist_a >= dist_t'(1))
                    && (dist_a > best_len_reg))
                begin
                    best_len_next  = dist_a;
                    best_node_next = field_t'(scan_idx_reg);
                end
                scan_idx_next = scan_idx_reg + node_cnt_t'(1);
                state_next    = ST_SCAN_RD;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            edge_idx_reg <= '0;
            pass_cnt_reg <= '0;
            grew_reg     <= 1'b0;
            cycle_reg    <= 1'b0;
            scan_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            edge_idx_reg <= edge_idx_next;
            pass_cnt_reg <= pass_cnt_next;
            grew_reg     <= grew_next;
            cycle_reg    <= cycle_next;
            scan_idx_reg <= scan_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg      <= head_next;
        best_len_reg  <= best_len_next;
        best_node_reg <= best_node_next;
    end

    always_comb
    begin
        if (cycle_reg)
        begin
            res.path_length = '0;
            res.end_node    = '0;
            res.error_code  = ERR_CYCLE;
        end
        else
        begin
            res.path_length = best_len_reg[FIELD_W-1:0];
            res.end_node    = best_node_reg;
            res.error_code  = edge_stat.overflow ? ERR_OVERFLOW : ERR_OK;
        end
    end

    assign idle = (state_reg == ST_IDLE);

    `DLP_ASSERT_IMP(a_accept_idle, in_accept, state_reg == ST_IDLE, "beat taken while busy")
    `DLP_ASSERT_IMP(a_dist_wr_state, dist_req.wr_en, (state_reg == ST_UPD) || (state_reg == ST_IDLE), "stray distance write")
    `DLP_ASSERT_IMP(a_pass_bound, state_reg != ST_IDLE, pass_cnt_reg <= node_cnt_t'(NODES), "pass count ran past the node count")

endmodule

### bench/tb_dag_longest_path_search_core.sv
`timescale 1ns / 100ps
// Testbench of the longest path search core: graph loads and searches on the stream
// ports, checked beat by beat against a behavioral predictor. Depends on dlp_pkg and the core.
module tb_dag_longest_path_search_core;
    import dlp_pkg::*;

    localparam int    HALF_PERIOD      = 10;
    localparam int    RESET_CYCLES     = 9;
    localparam int    RANDOM_ITEMS     = 265;
    localparam int    MAX_RANDOM_EDGES = 40;
    localparam int    HOLD_OFF_AT      = 2;
    localparam int    HOLD_OFF_CYCLES  = 3000;
    localparam int    IDLE_LIMIT       = 1200000;
    localparam int    DRAIN_CYCLES     = 300;
    localparam mode_t MODE_UNUSED      = 2'd3;

    typedef struct packed {
        mode_t  mode;
        field_t from;
        field_t to;
        field_t src;
    } cmd_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    cmd_beat_t pending_beats [$];
    result_t   awaited_results [$];
    cmd_beat_t beat_on_bus;

    // Predicted graph state.
    field_t edge_tail [EDGES];
    field_t edge_head [EDGES];
    int     stored_edges = 0;
    bit     store_overflowed = 1'b0;
    dist_t  reach_dist [NODES];

    int planned_edges = 0;
    int planned_items = 0;
    int mismatch_count = 0;
    int results_seen = 0;
    int send_gap = 0;
    int recv_wait = 0;
    int quiet_cycles = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;

    dag_longest_path_search_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic field_t any_node();
        return field_t'($urandom_range(0, NODES - 1));
    endfunction

    function automatic void queue_beat(mode_t m, field_t f, field_t t, field_t s);
        pending_beats.insert(pending_beats.size(), cmd_beat_t'{m, f, t, s});
        if (m == MODE_CLEAR)
            planned_edges = 0;
        else if (m == MODE_ADD)
            planned_edges++;
        if (m != MODE_UNUSED)
            planned_items++;
    endfunction

    // One sweep over the stored edges in order; distances wrap at the block's width.
    function automatic bit relax_pass();
        bit    grew = 1'b0;
        dist_t cand;
        for (int e = 0; e < stored_edges; e++)
        begin
            if (reach_dist[edge_tail[e]] == DIST_UNREACHED)
                continue;
            cand = reach_dist[edge_tail[e]] + dist_t'(1);
            if (reach_dist[edge_head[e]] == DIST_UNREACHED || cand > reach_dist[edge_head[e]])
            begin
                reach_dist[edge_head[e]] = cand;
                grew = 1'b1;
            end
        end
        return grew;
    endfunction

    function automatic result_t longest_path_from(field_t src);
        result_t res;
        bit      grew = 1'b1;
        bit      cyclic = 1'b0;
        int      best_len = 0;
        int      best_node = 0;
        foreach (reach_dist[i])
            reach_dist[i] = DIST_UNREACHED;
        reach_dist[src] = '0;
        for (int r = 0; r + 1 < NODES && grew; r++)
            grew = relax_pass();
        // Still growing after NODES-1 sweeps means a cycle is reachable.
        if (grew)
            cyclic = relax_pass();
        if (cyclic)
        begin
            res.path_length = '0;
            res.end_node = '0;
            res.error_code = ERR_CYCLE;
            return res;
        end
        for (int i = 0; i < NODES; i++)
        begin
            if (reach_dist[i] != DIST_UNREACHED && reach_dist[i] >= 1 &&
                int'(reach_dist[i]) > best_len)
            begin
                best_len = int'(reach_dist[i]);
                best_node = i;
            end
        end
        res.path_length = field_t'(best_len);
        res.end_node = field_t'(best_node);
        res.error_code = store_overflowed ? ERR_OVERFLOW : ERR_OK;
        return res;
    endfunction

    function automatic void absorb_command(cmd_beat_t b);
        case (b.mode)
            MODE_CLEAR:
            begin
                stored_edges = 0;
                store_overflowed = 1'b0;
            end
            MODE_ADD:
            begin
                if (stored_edges >= EDGES)
                    store_overflowed = 1'b1;
                else
                begin
                    edge_tail[stored_edges] = b.from;
                    edge_head[stored_edges] = b.to;
                    stored_edges++;
                end
            end
            MODE_RUN:
                awaited_results.insert(awaited_results.size(), longest_path_from(b.src));
            default:
                ;
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(result_t got);
        result_t want;
        if (awaited_results.size() == 0)
        begin
            report_mismatch("unexpected result beat, path_length", int'(got.path_length), 0);
            return;
        end
        want = awaited_results.pop_front();
        if (got.path_length !== want.path_length)
            report_mismatch("path_length", int'(got.path_length), int'(want.path_length));
        if (got.end_node !== want.end_node)
            report_mismatch("end_node", int'(got.end_node), int'(want.end_node));
        if (got.error_code !== want.error_code)
            report_mismatch("error_code", int'(got.error_code), int'(want.error_code));
    endtask

    // Sender: one beat offered at a time, with a random gap before the next one.
    always @(posedge clk or negedge rst_n)
    begin
        bit offering;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            send_gap = 0;
        end
        else
        begin
            offering = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_command(beat_on_bus);
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_beats.size() > 0)
                begin
                    beat_on_bus = pending_beats.pop_front();
                    s_axis_tdata <= S_TDATA_W'({beat_on_bus.src, beat_on_bus.to,
                                                beat_on_bus.from});
                    s_axis_tuser <= beat_on_bus.mode;
                    offering = 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        send_calm = !send_calm;
                    send_gap = send_calm ? 0 : $urandom_range(0, 14);
                end
            end
            s_axis_tvalid <= offering;
        end
    end

    // Receiver: random stalls after each result, and one long hold-off that lets
    // the block fill up and stall its input.
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.path_length = m_axis_tdata[FIELD_W-1:0];
                got.end_node = m_axis_tdata[2*FIELD_W-1:FIELD_W];
                got.error_code = m_axis_tuser;
                check_result(got);
                results_seen++;
                if (results_seen == HOLD_OFF_AT)
                    recv_wait = HOLD_OFF_CYCLES;
                else
                begin
                    if ($urandom_range(0, 15) == 0)
                        recv_calm = !recv_calm;
                    recv_wait = recv_calm ? 0 : $urandom_range(0, 14);
                end
            end
            else if (recv_wait > 0)
                recv_wait--;
            m_axis_tready <= (recv_wait == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("tb_dag_longest_path_search_core: errors");
                $finish;
            end
        end
    end

    initial
    begin
        int     kind;
        int     base;
        int     n_edges;
        int     n_runs;
        int     oa;
        int     ob;
        int     goal;

        // Directed part.
        queue_beat(MODE_RUN, 0, 0, 0);        // empty graph reaches nothing
        queue_beat(MODE_ADD, 0, 127, 0);
        queue_beat(MODE_ADD, 127, 1, 0);
        queue_beat(MODE_RUN, 0, 0, 0);
        queue_beat(MODE_RUN, 0, 0, 127);
        queue_beat(MODE_RUN, 0, 0, 5);        // isolated source
        queue_beat(MODE_UNUSED, 127, 127, 127);
        queue_beat(MODE_ADD, 3, 3, 127);      // self loop
        queue_beat(MODE_RUN, 127, 127, 3);
        queue_beat(MODE_RUN, 0, 0, 0);        // loop exists but is out of reach
        queue_beat(MODE_ADD, 1, 3, 0);
        queue_beat(MODE_RUN, 0, 0, 0);
        queue_beat(MODE_CLEAR, 127, 127, 127);
        queue_beat(MODE_RUN, 0, 0, 127);
        queue_beat(MODE_ADD, 10, 20, 0);
        queue_beat(MODE_ADD, 10, 15, 0);
        queue_beat(MODE_RUN, 0, 0, 10);       // tie between 15 and 20
        queue_beat(MODE_ADD, 20, 16, 0);
        queue_beat(MODE_ADD, 15, 40, 0);
        queue_beat(MODE_ADD, 10, 16, 0);      // shortcut must not shorten node 16
        queue_beat(MODE_RUN, 0, 0, 10);
        queue_beat(MODE_CLEAR, 0, 0, 0);

        // Random part: mostly a fresh graph in a window of nodes, forward edges with
        // a rare back edge, then a few searches.
        goal = planned_items + RANDOM_ITEMS;
        while (planned_items < goal)
        begin
            kind = $urandom_range(0, 9);
            base = $urandom_range(0, NODES - 16);
            if (kind < 8 || planned_edges > MAX_RANDOM_EDGES)
            begin
                if (kind != 0 || planned_edges > MAX_RANDOM_EDGES)
                    queue_beat(MODE_CLEAR, any_node(), any_node(), any_node());
                n_edges = $urandom_range(1, 16);
                for (int k = 0; k < n_edges; k++)
                begin
                    oa = $urandom_range(0, 14);
                    ob = $urandom_range(oa + 1, 15);
                    if ($urandom_range(0, 39) == 0)
                        queue_beat(MODE_ADD, field_t'(base + ob), field_t'(base + oa),
                                   any_node());
                    else
                        queue_beat(MODE_ADD, field_t'(base + oa), field_t'(base + ob),
                                   any_node());
                end
                n_runs = $urandom_range(1, 3);
                for (int k = 0; k < n_runs; k++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        queue_beat(MODE_RUN, any_node(), any_node(), any_node());
                    else
                        queue_beat(MODE_RUN, any_node(), any_node(),
                                   field_t'(base + $urandom_range(0, 15)));
                end
            end
            else if (kind == 8)
            begin
                repeat ($urandom_range(1, 3))
                    queue_beat(MODE_UNUSED, any_node(), any_node(), any_node());
                repeat ($urandom_range(1, 4))
                    queue_beat(MODE_ADD, any_node(), any_node(), any_node());
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    queue_beat(MODE_CLEAR, any_node(), any_node(), any_node());
                queue_beat(MODE_RUN, any_node(), any_node(), any_node());
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_beats.size() != 0 || s_axis_tvalid || awaited_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("tb_dag_longest_path_search_core: clean");
        else
            $display("tb_dag_longest_path_search_core: errors");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/dlp_pkg.sv
rtl/dlp_edge_store.sv
rtl/dlp_dist_ram.sv
rtl/dlp_search_ctrl.sv
rtl/dag_longest_path_search_core.sv
bench/tb_dag_longest_path_search_core.sv
